// ===== rtl/core/ilp_pkg.sv =====
package ilp_pkg;

  typedef enum logic [2:0] {
    ST_MORE  = 3'd0,
    ST_FOUND = 3'd1,
    ST_PROTO = 3'd2,
    ST_UNSUP = 3'd3,
    ST_OVER  = 3'd4
  } status_t;

  localparam logic [2:0] REG_MAX_LINE_LENGTH = 3'd0;
  localparam logic [10:0] MAX_LINE_RESET = 11'd255;
  localparam logic [10:0] LINE_SAT = 11'd2047;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_LOW   = 8'h21;
  localparam logic [7:0] CH_HIGH  = 8'h7e;
  localparam logic [7:0] CH_DASH  = 8'h2d;

  localparam logic [3:0] PHASE_DONE = 4'd4;
  localparam logic [3:0] PHASE_MISS = 4'hf;

  localparam logic [1:0] VP_SCAN  = 2'd0;
  localparam logic [1:0] VP_SPACE = 2'd2;
  localparam logic [1:0] VP_BAD   = 2'd3;

  // Per-line parse state; the byte counters live outside since their width varies.
  typedef struct packed {
    logic [10:0] line_length;
    logic        cr_pending;
    logic [3:0]  prefix_phase;
    logic [1:0]  prefix_kind;
    logic [1:0]  version_phase;
    logic        version_nonempty;
  } line_state_t;

  typedef struct packed {
    status_t     status;
    logic [10:0] banner_length;
    logic [15:0] banner_offset;
    logic [15:0] consumed_count;
  } result_t;

  // "SSH-2.0-"
  function automatic logic [7:0] pat_v2(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0: ch = 8'h53;
      4'd1: ch = 8'h53;
      4'd2: ch = 8'h48;
      4'd3: ch = 8'h2d;
      4'd4: ch = 8'h32;
      4'd5: ch = 8'h2e;
      4'd6: ch = 8'h30;
      4'd7: ch = 8'h2d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "SSH-1.99-"
  function automatic logic [7:0] pat_v199(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0: ch = 8'h53;
      4'd1: ch = 8'h53;
      4'd2: ch = 8'h48;
      4'd3: ch = 8'h2d;
      4'd4: ch = 8'h31;
      4'd5: ch = 8'h2e;
      4'd6: ch = 8'h39;
      4'd7: ch = 8'h39;
      4'd8: ch = 8'h2d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [10:0] sat_line(input logic [10:0] v);
    return (v == LINE_SAT) ? v : v + 11'd1;
  endfunction

endpackage

// ===== rtl/core/ilp_step.sv =====
module ilp_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [7:0]             data_byte,
  input  logic                   restart,
  input  logic [10:0]            max_line_length,
  input  ilp_pkg::line_state_t   cur_line,
  input  logic [COUNT_WIDTH-1:0] cur_start,
  input  logic [COUNT_WIDTH-1:0] cur_total,
  output ilp_pkg::line_state_t   next_line,
  output logic [COUNT_WIDTH-1:0] next_start,
  output logic [COUNT_WIDTH-1:0] next_total,
  output ilp_pkg::result_t       res
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [15:0] out16(input logic [COUNT_WIDTH-1:0] v);
    return (v > COUNT_WIDTH'(65535)) ? 16'hffff : 16'(v);
  endfunction

  ilp_pkg::line_state_t   ls;
  logic [COUNT_WIDTH-1:0] st;
  logic [COUNT_WIDTH-1:0] tc;
  logic [10:0]            size;
  logic [10:0]            p;
  logic                   v2;
  logic                   v199;

  always_comb begin
    ls = restart ? '0 : cur_line;
    st = restart ? '0 : cur_start;
    tc = restart ? '0 : cur_total;
    next_line = ls;
    next_start = st;
    res = '0;
    res.status = ilp_pkg::ST_MORE;
    size = ls.line_length - 11'(ls.cr_pending);
    p = ls.line_length;
    v2 = 1'b0;
    v199 = 1'b0;

    if (ls.cr_pending && data_byte != ilp_pkg::CH_LF) begin
      res.status = ilp_pkg::ST_PROTO;
    end else if (data_byte == ilp_pkg::CH_CR) begin
      next_line.cr_pending = 1'b1;
      next_line.line_length = ilp_pkg::sat_line(ls.line_length);
    end else if (data_byte == ilp_pkg::CH_LF) begin
      if ({1'b0, ls.line_length} + 12'd1 > {1'b0, max_line_length}) begin
        res.status = ilp_pkg::ST_OVER;
      end else if (size >= 11'd4 && ls.prefix_phase == ilp_pkg::PHASE_DONE) begin
        v2 = size > 11'd8 && !ls.prefix_kind[0];
        v199 = size > 11'd9 && !ls.prefix_kind[1];
        if (!v2 && !v199) begin
          res.status = (size > 11'd8) ? ilp_pkg::ST_UNSUP : ilp_pkg::ST_PROTO;
        end else if (ls.version_phase == ilp_pkg::VP_BAD || !ls.version_nonempty) begin
          res.status = ilp_pkg::ST_PROTO;
        end else begin
          res.status = ilp_pkg::ST_FOUND;
          res.banner_length = size;
          res.banner_offset = out16(st);
          res.consumed_count = out16(sat_inc(tc));
        end
      end else begin
        // A line that is not an SSH line is skipped and the next one begins.
        next_line = '0;
        next_start = sat_inc(tc);
      end
    end else if (data_byte < ilp_pkg::CH_SPACE || data_byte == ilp_pkg::CH_DEL) begin
      res.status = ilp_pkg::ST_PROTO;
    end else begin
      if (p < 11'd4 && ls.prefix_phase != ilp_pkg::PHASE_MISS) begin
        next_line.prefix_phase = (data_byte == ilp_pkg::pat_v2(p[3:0])) ?
                                 p[3:0] + 4'd1 : ilp_pkg::PHASE_MISS;
      end
      if (p < 11'd8 && data_byte != ilp_pkg::pat_v2(p[3:0])) begin
        next_line.prefix_kind[0] = 1'b1;
      end
      if (p < 11'd9 && data_byte != ilp_pkg::pat_v199(p[3:0])) begin
        next_line.prefix_kind[1] = 1'b1;
      end
      // Past a still-matching version prefix, the bytes are the software version.
      if ((!next_line.prefix_kind[0] && p >= 11'd8) ||
          (!next_line.prefix_kind[1] && p >= 11'd9)) begin
        if (ls.version_phase == ilp_pkg::VP_SCAN) begin
          if (data_byte == ilp_pkg::CH_SPACE) begin
            next_line.version_phase = ilp_pkg::VP_SPACE;
          end else if (data_byte < ilp_pkg::CH_LOW || data_byte > ilp_pkg::CH_HIGH ||
                       data_byte == ilp_pkg::CH_DASH) begin
            next_line.version_phase = ilp_pkg::VP_BAD;
          end else begin
            next_line.version_nonempty = 1'b1;
          end
        end
      end
      next_line.line_length = ilp_pkg::sat_line(ls.line_length);
    end

    if (res.status == ilp_pkg::ST_MORE && next_line.line_length >= max_line_length) begin
      res.status = ilp_pkg::ST_OVER;
    end

    if (res.status == ilp_pkg::ST_MORE) begin
      next_total = sat_inc(tc);
    end else begin
      next_line = '0;
      next_start = '0;
      next_total = '0;
    end
  end

endmodule

// ===== rtl/core/identification_line_parser.sv =====
// A result beat is valid in the cycle after its byte beat is accepted. One byte
// per cycle while results are taken; the per-line state is updated in a single
// registered pass per byte, and the result register frees whenever it is taken.
// Reset (rst, synchronous, active high) clears the search state and the
// result valid flag, and sets max_line_length to 255.
module identification_line_parser #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [10:0] banner_length,
  output logic [15:0] banner_offset,
  output logic [15:0] consumed_count
);

  logic [10:0]            max_line_length;
  ilp_pkg::line_state_t   line_state;
  logic [COUNT_WIDTH-1:0] line_start;
  logic [COUNT_WIDTH-1:0] total_count;

  ilp_pkg::line_state_t   line_state_next;
  logic [COUNT_WIDTH-1:0] line_start_next;
  logic [COUNT_WIDTH-1:0] total_count_next;
  ilp_pkg::result_t       step_res;
  logic                   byte_accept;
  logic                   cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && paddr == ilp_pkg::REG_MAX_LINE_LENGTH;
  assign prdata = (paddr == ilp_pkg::REG_MAX_LINE_LENGTH) ? {21'd0, max_line_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= ilp_pkg::MAX_LINE_RESET;
    end else if (cfg_write) begin
      max_line_length <= pwdata[10:0];
    end
  end

  assign byte_ready = !result_valid || result_ready;
  assign byte_accept = byte_valid && byte_ready;

  ilp_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .data_byte(data_byte),
    .restart(restart),
    .max_line_length(max_line_length),
    .cur_line(line_state),
    .cur_start(line_start),
    .cur_total(total_count),
    .next_line(line_state_next),
    .next_start(line_start_next),
    .next_total(total_count_next),
    .res(step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state <= '0;
      line_start <= '0;
      total_count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (byte_accept) begin
        line_state <= line_state_next;
        line_start <= line_start_next;
        total_count <= total_count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      status <= step_res.status;
      banner_length <= step_res.banner_length;
      banner_offset <= step_res.banner_offset;
      consumed_count <= step_res.consumed_count;
    end
  end

  // A found banner carries at least a full version prefix and one version byte.
  a_found_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ilp_pkg::ST_FOUND |-> banner_length > 11'd8)
    else $error("found banner shorter than a version prefix");

  a_nonfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ilp_pkg::ST_FOUND |->
      banner_length == 11'd0 && banner_offset == 16'd0 && consumed_count == 16'd0)
    else $error("banner fields set without a found status");

  a_found_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ilp_pkg::ST_FOUND |-> consumed_count >= banner_offset)
    else $error("banner offset beyond bytes consumed");

  // Any terminal status restarts the search from offset zero.
  a_terminal_clear: assert property (@(posedge clk) disable iff (rst)
    byte_accept && step_res.status != ilp_pkg::ST_MORE |=>
      total_count == '0 && line_start == '0 && line_state == '0)
    else $error("search state not cleared after a terminal status");

endmodule
